### sv/srp_pkg.sv
// ============================================================================
// srp_pkg
// Shared types and codes for the skyline rectangle packer.
// ============================================================================
package srp_pkg;

   localparam int ITEM_W  = 13;
   localparam int PLACE_W = 12;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_RESET  = 2'd1;
   localparam logic [1:0] CMD_EXPAND = 2'd2;
   localparam logic [1:0] CMD_NOP    = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic [ITEM_W-1:0] item_width;
      logic [ITEM_W-1:0] item_height;
   } srp_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [PLACE_W-1:0] place_x;
      logic [PLACE_W-1:0] place_y;
   } srp_rsp_type;

endpackage

### sv/srp_seg_store.sv
// ============================================================================
// srp_seg_store
// Single-write, single-read segment memory with registered read data.
// Entry 0 reads as an empty root segment until it is first written.
// ============================================================================
module srp_seg_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 53
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;
   logic          fresh_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (fresh_ff && rd_addr == '0) begin
         rd_data_ff <= '0;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b1;
      end else if (wr_en && wr_addr == '0) begin
         fresh_ff <= 1'b0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/skyline_rect_packer_top.sv
// ============================================================================
// skyline_rect_packer_top
// Skyline bin packer: reset, expand and bottom-left add of rectangles.
// ============================================================================
// One request at a time; the block is not ready while it works on one. Reset,
// expand and unused commands pass from the dispatch state straight to the
// response state. An add reads every segment as a candidate start, walks the
// segments under each candidate that fits, then moves entries to insert the
// new segment, trims or removes the segments it covers, and checks neighbor
// pairs in a merge pass; every segment read takes an address state and a data
// state on the registered-read segment memory. A finished result moves into
// the output register as soon as that register is free, so the next request
// is taken while an earlier result still waits.
module skyline_rect_packer_top
   import srp_pkg::*;
#(
   parameter int MAX_SEGMENTS = 64,
   parameter int COORD_LIMIT  = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  srp_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output srp_rsp_type rsp_payload
);

   localparam int CW = $clog2(COORD_LIMIT + 1);
   localparam int KW = (CW > ITEM_W) ? CW : ITEM_W;
   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int NW = $clog2(MAX_SEGMENTS + 1);
   localparam int WW = KW + AW + 1;
   localparam int EW = WW + 2;
   localparam int DW = 2 * WW + CW;

   typedef enum logic [4:0] {
      S_IDLE, S_DISP, S_SCAN, S_SCAN_D, S_WALK, S_WALK_D, S_CAND, S_PLACE,
      S_INS, S_INS_D, S_RAISE, S_RAISE_D, S_REM, S_REM_D, S_MRG, S_MRG_A,
      S_MRG_B, S_RESP
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [NW-1:0] count_ff, count_in;
   logic [CW-1:0] atlas_w_ff, atlas_w_in, atlas_h_ff, atlas_h_in;
   logic          rsp_valid_ff, rsp_valid_in;
   srp_rsp_type   rsp_ff, rsp_in;
   srp_rsp_type   res_ff, res_in;

   logic [1:0]        cmd_ff, cmd_in;
   logic [ITEM_W-1:0] iw_ff, iw_in, ih_ff, ih_in;
   logic [NW-1:0]     i_ff, i_in, j_ff, j_in, k_ff, k_in, besti_ff, besti_in;
   logic [CW-1:0]     y_ff, y_in, besty_ff, besty_in;
   logic signed [EW-1:0] left_ff, left_in;
   logic [WW-1:0]     cx_ff, cx_in, cw_ff, cw_in, bestw_ff, bestw_in;
   logic [WW-1:0]     bestx_ff, bestx_in, edge_ff, edge_in;
   logic [EW-1:0]     besth_ff, besth_in;
   logic              found_ff, found_in;

   logic          wr_en;
   logic [NW-1:0] wr_idx, rd_idx;
   logic [DW-1:0] wr_data, rd_data;
   logic [WW-1:0] rd_x, rd_w;
   logic [CW-1:0] rd_y, ny, w_sat, h_sat;
   logic [EW-1:0] top;
   logic signed [EW-1:0] nw;
   logic [WW:0]   msum;
   logic [WW-1:0] msat;

   srp_seg_store #(
      .DEPTH (MAX_SEGMENTS),
      .AW    (AW),
      .DW    (DW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rd_x = rd_data[DW-1 -: WW];
   assign rd_y = rd_data[WW +: CW];
   assign rd_w = rd_data[WW-1:0];
   assign ny   = (rd_y > y_ff) ? rd_y : y_ff;
   assign top  = EW'(y_ff) + EW'(ih_ff);
   assign nw   = $signed(EW'(rd_w)) + $signed(EW'(rd_x)) - $signed(EW'(edge_ff));
   assign msum = {1'b0, cw_ff} + {1'b0, rd_w};
   assign msat = msum[WW] ? '1 : msum[WW-1:0];
   assign w_sat = (EW'(iw_ff) > EW'(COORD_LIMIT)) ? CW'(COORD_LIMIT) : CW'(iw_ff);
   assign h_sat = (EW'(ih_ff) > EW'(COORD_LIMIT)) ? CW'(COORD_LIMIT) : CW'(ih_ff);

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in = state_ff;   ret_in = ret_ff;       count_in = count_ff;
      atlas_w_in = atlas_w_ff; atlas_h_in = atlas_h_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;    rsp_in = rsp_ff;
      res_in = res_ff;
      cmd_in = cmd_ff;       iw_in = iw_ff;         ih_in = ih_ff;
      i_in = i_ff;           j_in = j_ff;           k_in = k_ff;
      besti_in = besti_ff;   y_in = y_ff;           besty_in = besty_ff;
      left_in = left_ff;     cx_in = cx_ff;         cw_in = cw_ff;
      bestw_in = bestw_ff;   bestx_in = bestx_ff;   edge_in = edge_ff;
      besth_in = besth_ff;   found_in = found_ff;
      wr_en = 1'b0;          wr_idx = '0;           wr_data = '0;
      rd_idx = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_payload.command;
               iw_in = req_payload.item_width;
               ih_in = req_payload.item_height;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            res_in = '{status: ST_OK, place_x: '0, place_y: '0};
            state_in = S_RESP;
            unique case (cmd_ff)
               CMD_ADD: begin
                  found_in = 1'b0;
                  besth_in = EW'(atlas_h_ff);
                  bestw_in = WW'(atlas_w_ff);
                  i_in = '0;
                  state_in = S_SCAN;
               end
               CMD_RESET: begin
                  atlas_w_in = w_sat;
                  atlas_h_in = h_sat;
                  count_in = NW'(1);
                  wr_en = 1'b1;
                  wr_data = {WW'(0), CW'(0), WW'(w_sat)};
               end
               CMD_EXPAND: begin
                  if (w_sat > atlas_w_ff) begin
                     if (count_ff >= NW'(MAX_SEGMENTS)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        wr_en = 1'b1;
                        wr_idx = count_ff;
                        wr_data = {WW'(atlas_w_ff), CW'(0), WW'(w_sat - atlas_w_ff)};
                        count_in = count_ff + NW'(1);
                        atlas_w_in = w_sat;
                        atlas_h_in = h_sat;
                     end
                  end else begin
                     atlas_w_in = w_sat;
                     atlas_h_in = h_sat;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            rd_idx = i_ff;
            state_in = (i_ff >= count_ff) ? S_PLACE : S_SCAN_D;
         end
         S_SCAN_D: begin
            cx_in = rd_x;
            cw_in = rd_w;
            if (EW'(rd_x) + EW'(iw_ff) > EW'(atlas_w_ff)) begin
               i_in = i_ff + NW'(1);
               state_in = S_SCAN;
            end else begin
               y_in = rd_y;
               left_in = $signed(EW'(iw_ff));
               j_in = i_ff;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            rd_idx = j_ff;
            if (left_ff <= 0) begin
               state_in = S_CAND;
            end else if (j_ff >= count_ff) begin
               i_in = i_ff + NW'(1);
               state_in = S_SCAN;
            end else begin
               state_in = S_WALK_D;
            end
         end
         S_WALK_D: begin
            if (EW'(ny) + EW'(ih_ff) > EW'(atlas_h_ff)) begin
               i_in = i_ff + NW'(1);
               state_in = S_SCAN;
            end else begin
               y_in = ny;
               left_in = left_ff - $signed(EW'(rd_w));
               j_in = j_ff + NW'(1);
               state_in = S_WALK;
            end
         end
         S_CAND: begin
            if (top < besth_ff || (top == besth_ff && cw_ff < bestw_ff)) begin
               found_in = 1'b1;
               besti_in = i_ff;
               bestw_in = cw_ff;
               besth_in = top;
               bestx_in = cx_ff;
               besty_in = y_ff;
            end
            i_in = i_ff + NW'(1);
            state_in = S_SCAN;
         end
         S_PLACE: begin
            if (!found_ff) begin
               res_in.status = ST_NOFIT;
               state_in = S_RESP;
            end else if (count_ff >= NW'(MAX_SEGMENTS)) begin
               res_in.status = ST_FULL;
               state_in = S_RESP;
            end else begin
               k_in = count_ff;
               state_in = S_INS;
            end
         end
         S_INS: begin
            rd_idx = k_ff - NW'(1);
            if (k_ff == besti_ff) begin
               wr_en = 1'b1;
               wr_idx = besti_ff;
               wr_data = {bestx_ff, CW'(EW'(besty_ff) + EW'(ih_ff)), WW'(iw_ff)};
               count_in = count_ff + NW'(1);
               edge_in = WW'(EW'(bestx_ff) + EW'(iw_ff));
               i_in = besti_ff + NW'(1);
               state_in = S_RAISE;
            end else begin
               state_in = S_INS_D;
            end
         end
         S_INS_D: begin
            wr_en = 1'b1;
            wr_idx = k_ff;
            wr_data = rd_data;
            k_in = k_ff - NW'(1);
            state_in = S_INS;
         end
         S_RAISE: begin
            rd_idx = i_ff;
            if (i_ff >= count_ff) begin
               i_in = '0;
               state_in = S_MRG;
            end else begin
               state_in = S_RAISE_D;
            end
         end
         S_RAISE_D: begin
            if (rd_x >= edge_ff) begin
               i_in = '0;
               state_in = S_MRG;
            end else if (nw > 0) begin
               wr_en = 1'b1;
               wr_idx = i_ff;
               wr_data = {edge_ff, rd_y, WW'(nw)};
               i_in = '0;
               state_in = S_MRG;
            end else begin
               k_in = i_ff;
               ret_in = S_RAISE;
               state_in = S_REM;
            end
         end
         S_REM: begin
            rd_idx = k_ff + NW'(1);
            if ((NW+1)'(k_ff) + (NW+1)'(1) >= (NW+1)'(count_ff)) begin
               count_in = count_ff - NW'(1);
               state_in = ret_ff;
            end else begin
               state_in = S_REM_D;
            end
         end
         S_REM_D: begin
            wr_en = 1'b1;
            wr_idx = k_ff;
            wr_data = rd_data;
            k_in = k_ff + NW'(1);
            state_in = S_REM;
         end
         S_MRG: begin
            rd_idx = i_ff;
            if ((NW+1)'(i_ff) + (NW+1)'(1) >= (NW+1)'(count_ff)) begin
               res_in.place_x = PLACE_W'(bestx_ff);
               res_in.place_y = PLACE_W'(besty_ff);
               state_in = S_RESP;
            end else begin
               state_in = S_MRG_A;
            end
         end
         S_MRG_A: begin
            rd_idx = i_ff + NW'(1);
            cx_in = rd_x;
            y_in = rd_y;
            cw_in = rd_w;
            state_in = S_MRG_B;
         end
         S_MRG_B: begin
            if (y_ff == rd_y) begin
               wr_en = 1'b1;
               wr_idx = i_ff;
               wr_data = {cx_ff, y_ff, msat};
               k_in = i_ff + NW'(1);
               ret_in = S_MRG;
               state_in = S_REM;
            end else begin
               i_in = i_ff + NW'(1);
               state_in = S_MRG;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in = res_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff <= S_IDLE;
         count_ff <= NW'(1);
         atlas_w_ff <= '0;
         atlas_h_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         count_ff <= count_in;
         atlas_w_ff <= atlas_w_in;
         atlas_h_ff <= atlas_h_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;     iw_ff <= iw_in;       ih_ff <= ih_in;
      i_ff <= i_in;         j_ff <= j_in;         k_ff <= k_in;
      besti_ff <= besti_in; y_ff <= y_in;         besty_ff <= besty_in;
      left_ff <= left_in;   cx_ff <= cx_in;       cw_ff <= cw_in;
      bestw_ff <= bestw_in; bestx_ff <= bestx_in; edge_ff <= edge_in;
      besth_ff <= besth_in; found_ff <= found_in; res_ff <= res_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= NW'(MAX_SEGMENTS))
      else $error("segment count out of range");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff) && count_ff != $past(count_ff) + NW'(1) &&
       count_ff != $past(count_ff) - NW'(1)) |-> count_ff == NW'(1))
      else $error("segment count jumped");

   a_write_bound: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_idx <= count_ff && wr_idx < NW'(MAX_SEGMENTS))
      else $error("segment write beyond list");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

endmodule
